### sv/rmta_pkg.sv
// shared widths, codes, types and arithmetic helpers for the trend average filter
package rmta_pkg;

    localparam int SAMPLE_W        = 32;
    localparam int DATA_W          = 48;
    localparam int PERIOD_W        = 16;
    localparam int WEIGHT_BITS     = 16;
    localparam int WEIGHT_W        = WEIGHT_BITS + 1;
    localparam int PROD_W          = DATA_W + WEIGHT_W + 1;
    localparam int SUM_W           = PROD_W - WEIGHT_BITS;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = WEIGHT_W;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_BETA   = CFG_INDEX_W'(1);

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1);
    localparam logic [WEIGHT_W-1:0] BETA_RESET   = WEIGHT_W'(32768);
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = WEIGHT_W'(1) << WEIGHT_BITS;
    localparam logic [PROD_W-1:0]   ROUND_HALF   = PROD_W'(1) << (WEIGHT_BITS - 1);

    typedef enum logic {
        W_BETA,
        W_ALPHA
    } t_wsel;

    typedef enum logic [1:0] {
        OP_X,
        OP_B,
        OP_AVG,
        OP_D
    } t_osel;

    typedef struct packed {
        logic  x_load;
        logic  mul_en;
        t_wsel wsel;
        t_osel osel;
        logic  acc_load;
        logic  nb_load;
        logic  d_load;
        logic  d_seed;
        logic  b_load;
        logic  avg_load;
        logic  out_load;
    } t_dp_cmd;

    // round half up, then floor shift by the weight fraction bits
    function automatic logic signed [SUM_W-1:0] round_w(input logic signed [PROD_W-1:0] v);
        logic [PROD_W-1:0] t;
        t = v + ROUND_HALF;
        return $signed(t[PROD_W-1:WEIGHT_BITS]);
    endfunction

    function automatic logic signed [DATA_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-DATA_W:0] top;
        top = v[SUM_W-1:DATA_W-1];
        if ((&top) || !(|top)) begin
            return v[DATA_W-1:0];
        end else if (v[SUM_W-1]) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

endpackage

### sv/rmta_dp.sv
// datapath: shared weight multiplier, accumulator, filter state and output register
module rmta_dp
    import rmta_pkg::*;
(
    input  logic                       i_clk,
    input  t_dp_cmd                    i_cmd,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [WEIGHT_W-1:0]        i_beta,
    output logic signed [DATA_W-1:0]   o_result
);

    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [DATA_W-1:0]   r_b;
    logic signed [DATA_W-1:0]   r_avg;
    logic signed [DATA_W-1:0]   r_nb;
    logic signed [DATA_W-1:0]   r_d;
    logic signed [DATA_W-1:0]   r_out;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [PROD_W-1:0]   r_acc;

    logic [WEIGHT_W-1:0]        w_beta;
    logic [WEIGHT_W-1:0]        w_alpha;
    logic signed [WEIGHT_W:0]   mul_a;
    logic signed [DATA_W-1:0]   mul_b;
    logic signed [SUM_W-1:0]    x_ext;
    logic signed [SUM_W-1:0]    d_sub;
    logic signed [SUM_W-1:0]    nb_sum;
    logic signed [SUM_W-1:0]    d_sum;
    logic signed [SUM_W-1:0]    avg_rnd;
    logic signed [PROD_W-1:0]   blend_sum;

    always_comb begin
        w_beta  = (i_beta > WEIGHT_ONE) ? WEIGHT_ONE : i_beta;
        w_alpha = WEIGHT_ONE - w_beta;
        mul_a   = $signed({1'b0, (i_cmd.wsel == W_ALPHA) ? w_alpha : w_beta});
        case (i_cmd.osel)
            OP_X:    mul_b = {{(DATA_W-SAMPLE_W){r_x[SAMPLE_W-1]}}, r_x};
            OP_B:    mul_b = r_b;
            OP_AVG:  mul_b = r_avg;
            OP_D:    mul_b = r_d;
            default: mul_b = r_d;
        endcase
        x_ext     = {{(SUM_W-SAMPLE_W){r_x[SAMPLE_W-1]}}, r_x};
        d_sub     = i_cmd.d_seed ? '0 : {{(SUM_W-DATA_W){r_b[DATA_W-1]}}, r_b};
        nb_sum    = round_w(r_prod) + x_ext;
        d_sum     = x_ext + {{(SUM_W-DATA_W){r_nb[DATA_W-1]}}, r_nb} - d_sub;
        blend_sum = r_acc + r_prod;
        avg_rnd   = round_w(blend_sum);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.x_load) begin
            r_x <= i_sample;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.acc_load) begin
            r_acc <= r_prod;
        end
        if (i_cmd.nb_load) begin
            r_nb <= sat48(nb_sum);
        end
        if (i_cmd.d_load) begin
            r_d <= sat48(d_sum);
        end
        if (i_cmd.b_load) begin
            r_b <= r_nb;
        end
        if (i_cmd.avg_load) begin
            r_avg <= avg_rnd[DATA_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_out <= r_avg;
        end
    end

    assign o_result = r_out;

endmodule

### sv/rmta_ctrl.sv
// controller: sequences seed and update steps, tracks warm-up and output valid
module rmta_ctrl
    import rmta_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_restart,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  logic [PERIOD_W-1:0] i_period,
    output t_dp_cmd             o_cmd
);

    localparam int CMP_W = (COUNT_WIDTH > PERIOD_W) ? COUNT_WIDTH : PERIOD_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_S1,
        ST_S2,
        ST_S3,
        ST_S4,
        ST_S5,
        ST_U1,
        ST_U2,
        ST_U3,
        ST_U4,
        ST_U5,
        ST_OUT
    } t_state;

    t_state                 r_state;
    logic [COUNT_WIDTH-1:0] r_count;
    logic                   r_seeded;
    logic                   r_emit;
    logic                   r_out_valid;

    logic [PERIOD_W-1:0]    per_m1;
    logic                   warm_done;
    logic                   out_free;

    always_comb begin
        per_m1    = (i_period == '0) ? '0 : i_period - PERIOD_W'(1);
        warm_done = CMP_W'(r_count) >= CMP_W'(per_m1);
        out_free  = !r_out_valid || i_out_ready;
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.wsel     = W_BETA;
        o_cmd.osel     = OP_X;
        case (r_state)
            ST_IDLE: o_cmd.x_load = i_in_valid;
            ST_S1: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.osel   = OP_X;
            end
            ST_S2: begin
                o_cmd.nb_load  = 1'b1;
                o_cmd.acc_load = 1'b1;
            end
            ST_S3: begin
                o_cmd.b_load = 1'b1;
                o_cmd.d_load = 1'b1;
                o_cmd.d_seed = 1'b1;
            end
            ST_S4: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.wsel   = W_ALPHA;
                o_cmd.osel   = OP_D;
            end
            ST_S5: o_cmd.avg_load = 1'b1;
            ST_U1: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.osel   = OP_B;
            end
            ST_U2: begin
                o_cmd.nb_load = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.osel    = OP_AVG;
            end
            ST_U3: begin
                o_cmd.acc_load = 1'b1;
                o_cmd.d_load   = 1'b1;
            end
            ST_U4: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.wsel   = W_ALPHA;
                o_cmd.osel   = OP_D;
                o_cmd.b_load = 1'b1;
            end
            ST_U5:   o_cmd.avg_load = 1'b1;
            ST_OUT:  o_cmd.out_load = out_free;
            default: o_cmd.x_load   = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_seeded    <= 1'b0;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == ST_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        if (i_restart || !r_seeded) begin
                            r_seeded <= 1'b1;
                            r_count  <= COUNT_WIDTH'(1);
                            r_emit   <= (per_m1 == '0);
                            r_state  <= ST_S1;
                        end else begin
                            r_emit <= warm_done;
                            if (r_count != '1) begin
                                r_count <= r_count + COUNT_WIDTH'(1);
                            end
                            r_state <= ST_U1;
                        end
                    end
                end
                ST_S1: r_state <= ST_S2;
                ST_S2: r_state <= ST_S3;
                ST_S3: r_state <= ST_S4;
                ST_S4: r_state <= ST_S5;
                ST_S5: r_state <= r_emit ? ST_U1 : ST_IDLE;
                ST_U1: r_state <= ST_U2;
                ST_U2: r_state <= ST_U3;
                ST_U3: r_state <= ST_U4;
                ST_U4: r_state <= ST_U5;
                ST_U5: r_state <= r_emit ? ST_OUT : ST_IDLE;
                ST_OUT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### sv/recursive_moving_trend_average.sv
// top level: recursive moving trend average filter with configuration registers
//
// usage: one price sample per input transaction on the s side; tdata holds the
// signed sample with 16 fraction bits, tuser the restart flag that seeds a new
// series. each sample past warm-up gives one output transaction on the m side
// carrying the 48-bit trend average, truncated from the rounded blend.
// configuration: i_cfg_we with i_cfg_index 0 writes period, 1 writes beta;
// other indexes are ignored. write only while idle.
// sequencing: a seed sample runs steps S1 to S5 before the next sample is
// accepted; an updating sample runs U1 to U5, and then OUT when it gives a
// result, which OUT loads into the output register; a seed with period 1 runs
// S1 to S5, then U1 to U5 and OUT. the steps are set by the dependent multiplies
// going through one shared 18x48 multiplier.
// reset: the filter is unseeded, period is 1, beta is one half.
// stall: the output register holds a result while the receiver stalls; the
// next sample is still accepted and worked on, and its result waits until the
// held one has been taken.
module recursive_moving_trend_average
    import rmta_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [SAMPLE_W-1:0]    i_s_tdata,   // [31:0] sample
    input  logic                   i_s_tuser,   // [0] restart
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [DATA_W-1:0]      o_m_tdata,   // [47:0] trend_average
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [PERIOD_W-1:0]      r_period;
    logic [WEIGHT_W-1:0]      r_beta;
    t_dp_cmd                  dp_cmd;
    logic signed [DATA_W-1:0] result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
            r_beta   <= BETA_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PERIOD: r_period <= i_cfg_data[PERIOD_W-1:0];
                REG_BETA:   r_beta   <= i_cfg_data[WEIGHT_W-1:0];
                default:    r_period <= r_period;
            endcase
        end
    end

    rmta_ctrl #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .i_restart   (i_s_tuser),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .i_period    (r_period),
        .o_cmd       (dp_cmd)
    );

    rmta_dp u_dp (
        .i_clk    (i_clk),
        .i_cmd    (dp_cmd),
        .i_sample ($signed(i_s_tdata)),
        .i_beta   (r_beta),
        .o_result (result)
    );

    assign o_m_tdata = result;

endmodule
